FILE: rtl/ldbrc_pkg.sv
// ----------------------------------------------------------------------------
// ldbrc_pkg
// Shared types and constants of the loss driven bitrate controller: action
// codes, register indexes, loss thresholds and reset values.
// ----------------------------------------------------------------------------
package ldbrc_pkg;

	// result action codes
	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_DOWN = 2'd1,
		ACT_UP   = 2'd2
	} action_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MIN_RATE      = 3'd0,
		REG_MAX_RATE      = 3'd1,
		REG_INC_STEP      = 3'd2,
		REG_DEC_COOLDOWN  = 3'd3,
		REG_CLEAN_NEEDED  = 3'd4,
		REG_INC_INTERVAL  = 3'd5,
		REG_START_RATE    = 3'd6,
		REG_UNUSED        = 3'd7
	} reg_index_t;

	localparam int RATE_W = 31;
	localparam int MS_W   = 20;
	localparam int CNT_W  = 8;
	localparam int LOSS_W = 17;
	localparam int TIME_W = 32;

	// loss thresholds in Q0.16: 3 percent and 10 percent, rounded up
	localparam logic [LOSS_W-1:0] LOSS_LIGHT = 17'd1967;
	localparam logic [LOSS_W-1:0] LOSS_HEAVY = 17'd6554;

	// reciprocal of five for a 32 bit operand, used with a shift of 34
	localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
	localparam int RECIP5_SHIFT = 34;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	// reset values
	localparam logic [RATE_W-1:0] RST_MIN_RATE     = 31'd10000000;
	localparam logic [RATE_W-1:0] RST_MAX_RATE     = 31'd50000000;
	localparam logic [RATE_W-1:0] RST_INC_STEP     = 31'd5000000;
	localparam logic [MS_W-1:0]   RST_DEC_COOLDOWN = 20'd300;
	localparam logic [CNT_W-1:0]  RST_CLEAN_NEEDED = 8'd3;
	localparam logic [MS_W-1:0]   RST_INC_INTERVAL = 20'd1000;
	localparam logic [RATE_W-1:0] RST_START_RATE   = 31'd20000000;
	localparam logic [RATE_W-1:0] RST_CUR_RATE     = 31'd25000000;

	// floor(k * r / 5) for remainder r of a divide by five, k is 3 or 4
	function automatic logic [1:0] frac_of_rem(logic [2:0] r, logic heavy);
		logic [1:0] f;
		f = 2'd0;
		case (r)
			3'd2: f = 2'd1;
			3'd3: f = heavy ? 2'd1 : 2'd2;
			3'd4: f = heavy ? 2'd2 : 2'd3;
			default: f = 2'd0;
		endcase
		return f;
	endfunction

endpackage

FILE: rtl/loss_driven_bitrate_controller.sv
// ----------------------------------------------------------------------------
// loss_driven_bitrate_controller
// Additive increase, multiplicative decrease bitrate control from loss reports.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid / in_stall) takes one loss report per transfer:
//    loss_fraction in Q0.16 and a wrapping millisecond timestamp now_ms
//  - output channel (out_valid / out_stall) gives one result per report:
//    new_rate, rate_changed and action (none, decrease, increase)
//  - configuration channel (cfg_valid / cfg_ready) writes register cfg_index
//    with cfg_data; cfg_ready is always high, writes of zero are ignored, and
//    a write to start_rate reloads the current bitrate
//  - a report is held in the input register, then its result in the result
//    register, which drives the output port
//  - throughput is one report per cycle while the output is not stalled;
//    the whole decision, with the divide by five done as a reciprocal
//    multiply, is combinational between the input and result registers;
//    the state updates with the result register, so the next report sees it
//  - when the receiver stalls, the result register holds; a report waiting
//    in the input register then stalls the input channel
//  - reset loads the register defaults and the state reset values and
//    empties both registers
//  - configuration is to be written only while no report is in flight; the block itself does not enforce this
module loss_driven_bitrate_controller (
	input  logic        clk,
	input  logic        arst_n,
	// loss report input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [16:0] loss_fraction,
	input  logic [31:0] now_ms,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] new_rate,
	output logic        rate_changed,
	output logic [1:0]  action,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration registers
	logic [30:0] min_rate_q;
	logic [30:0] max_rate_q;
	logic [30:0] inc_step_q;
	logic [19:0] dec_cooldown_q;
	logic [7:0]  clean_needed_q;
	logic [19:0] inc_interval_q;
	logic [30:0] start_rate_q;

	// controller state
	logic [30:0] cur_rate_q;
	logic [7:0]  clean_cnt_q;
	logic [31:0] last_change_q;

	// input register
	logic        valid_s1;
	logic [16:0] loss_s1;
	logic [31:0] now_s1;

	// result register
	logic                  out_valid_q;
	logic [30:0]           new_rate_q;
	ldbrc_pkg::action_t    action_q;

	// handshake
	logic advance;
	logic in_take;
	logic cfg_take;

	// decision logic
	logic [31:0]           since;
	logic                  lossy;
	logic                  heavy;
	logic [62:0]           prod;
	logic [28:0]           quot;
	logic [30:0]           quot5;
	logic [2:0]            rem;
	logic [30:0]           target_dn;
	logic [31:0]           sum_up;
	logic [7:0]            cnt_inc;
	logic [30:0]           rate_n;
	logic [7:0]            cnt_n;
	logic [31:0]           last_n;
	ldbrc_pkg::action_t    act_n;

	// cfg values masked to register widths
	logic [30:0] cfg_rate;
	logic [19:0] cfg_ms;
	logic [7:0]  cfg_cnt;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign cfg_rate  = cfg_data[30:0];
	assign cfg_ms    = cfg_data[19:0];
	assign cfg_cnt   = cfg_data[7:0];

	// pipeline flow control
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			loss_s1 <= loss_fraction;
			now_s1  <= now_ms;
		end
	end

	// decrease target: floor(rate * k / 5) via quotient and remainder of rate / 5
	always_comb begin
		prod      = 63'(cur_rate_q) * 63'(ldbrc_pkg::RECIP5);
		quot      = prod[62:ldbrc_pkg::RECIP5_SHIFT];
		quot5     = {quot, 2'b00} + 31'(quot);
		rem       = 3'(cur_rate_q - quot5);
		heavy     = loss_s1 >= ldbrc_pkg::LOSS_HEAVY;
		if (heavy) begin
			target_dn = 31'(quot) + {quot, 1'b0}
				+ 31'(ldbrc_pkg::frac_of_rem(rem, 1'b1));
		end else begin
			target_dn = {quot, 2'b00} + 31'(ldbrc_pkg::frac_of_rem(rem, 1'b0));
		end
	end

	// next state and action for the report in the input register
	always_comb begin
		since   = now_s1 - last_change_q;
		lossy   = loss_s1 >= ldbrc_pkg::LOSS_LIGHT;
		cnt_inc = (clean_cnt_q == ldbrc_pkg::CNT_MAX) ? clean_cnt_q : clean_cnt_q + 8'd1;
		sum_up  = {1'b0, cur_rate_q} + {1'b0, inc_step_q};
		rate_n  = cur_rate_q;
		cnt_n   = cnt_inc;
		last_n  = last_change_q;
		act_n   = ldbrc_pkg::ACT_NONE;
		if (lossy) begin
			cnt_n = '0;
			if (since >= {12'd0, dec_cooldown_q}) begin
				rate_n = (target_dn > min_rate_q) ? target_dn : min_rate_q;
				last_n = now_s1;
				act_n  = ldbrc_pkg::ACT_DOWN;
			end
		end else if (since >= {12'd0, inc_interval_q} && cnt_inc >= clean_needed_q) begin
			cnt_n = '0;
			if (sum_up <= {1'b0, max_rate_q}) begin
				rate_n = sum_up[30:0];
				last_n = now_s1;
				act_n  = ldbrc_pkg::ACT_UP;
			end
		end
	end

	// configuration registers, zero writes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q     <= ldbrc_pkg::RST_MIN_RATE;
			max_rate_q     <= ldbrc_pkg::RST_MAX_RATE;
			inc_step_q     <= ldbrc_pkg::RST_INC_STEP;
			dec_cooldown_q <= ldbrc_pkg::RST_DEC_COOLDOWN;
			clean_needed_q <= ldbrc_pkg::RST_CLEAN_NEEDED;
			inc_interval_q <= ldbrc_pkg::RST_INC_INTERVAL;
			start_rate_q   <= ldbrc_pkg::RST_START_RATE;
		end else if (cfg_take) begin
			unique case (ldbrc_pkg::reg_index_t'(cfg_index))
				ldbrc_pkg::REG_MIN_RATE: begin
					if (cfg_rate != '0) min_rate_q <= cfg_rate;
				end
				ldbrc_pkg::REG_MAX_RATE: begin
					if (cfg_rate != '0) max_rate_q <= cfg_rate;
				end
				ldbrc_pkg::REG_INC_STEP: begin
					if (cfg_rate != '0) inc_step_q <= cfg_rate;
				end
				ldbrc_pkg::REG_DEC_COOLDOWN: begin
					if (cfg_ms != '0) dec_cooldown_q <= cfg_ms;
				end
				ldbrc_pkg::REG_CLEAN_NEEDED: begin
					if (cfg_cnt != '0) clean_needed_q <= cfg_cnt;
				end
				ldbrc_pkg::REG_INC_INTERVAL: begin
					if (cfg_ms != '0) inc_interval_q <= cfg_ms;
				end
				ldbrc_pkg::REG_START_RATE: begin
					if (cfg_rate != '0) start_rate_q <= cfg_rate;
				end
				default: begin
				end
			endcase
		end
	end

	// controller state: start_rate write reloads the rate, else report updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_rate_q    <= ldbrc_pkg::RST_CUR_RATE;
			clean_cnt_q   <= '0;
			last_change_q <= '0;
		end else if (cfg_take
				&& ldbrc_pkg::reg_index_t'(cfg_index) == ldbrc_pkg::REG_START_RATE) begin
			cur_rate_q <= (cfg_rate != '0) ? cfg_rate : start_rate_q;
		end else if (advance) begin
			cur_rate_q    <= rate_n;
			clean_cnt_q   <= cnt_n;
			last_change_q <= last_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			new_rate_q <= rate_n;
			action_q   <= act_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign new_rate     = new_rate_q;
	assign action       = action_q;
	assign rate_changed = (action_q != ldbrc_pkg::ACT_NONE);

endmodule

FILE: rtl/ldbrc_checker.sv
// ----------------------------------------------------------------------------
// ldbrc_checker
// Port level checks of the loss driven bitrate controller, bound to the top.
// ----------------------------------------------------------------------------
module ldbrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [30:0] new_rate,
	input logic        rate_changed,
	input logic [1:0]  action
);

	// rate_changed flags exactly the results that carry an adjustment
	a_changed_matches_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rate_changed == (action != ldbrc_pkg::ACT_NONE)))
		else $error("rate_changed disagrees with action");

	// only the three defined action codes appear
	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action == ldbrc_pkg::ACT_NONE || action == ldbrc_pkg::ACT_DOWN
			|| action == ldbrc_pkg::ACT_UP))
		else $error("undefined action code");

	// the input side stalls only behind a stalled, occupied result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(new_rate) && $stable(action)))
		else $error("stalled result changed");

endmodule

bind loss_driven_bitrate_controller ldbrc_checker u_ldbrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.new_rate     (new_rate),
	.rate_changed (rate_changed),
	.action       (action)
);
